// ===== rtl/mcgd_pkg.sv =====
// ============================================================================
// mcgd_pkg
// Shared constants and types of the MIDI clock gate divider.
// ============================================================================
package mcgd_pkg;

    localparam int NUM_DIVIDERS     = 4;
    localparam int NUM_GATE_OUTPUTS = 8;
    localparam int NUM_REGS         = 2 * NUM_DIVIDERS;
    localparam int CFG_INDEX_W      = 4;
    localparam int CFG_DATA_W       = 8;

    // MIDI real-time messages
    localparam logic [7:0] MSG_CLOCK = 8'hF8;
    localparam logic [7:0] MSG_START = 8'hFA;
    localparam logic [7:0] MSG_STOP  = 8'hFC;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ON_TICKS_A     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TICKS_A = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_TICKS_B     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TICKS_B = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_TICKS_C     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TICKS_C = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_TICKS_D     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TICKS_D = 4'd7;

    localparam logic [CFG_DATA_W-1:0] REG_RESET [NUM_REGS] =
        '{8'd3, 8'd6, 8'd2, 8'd4, 8'd1, 8'd2, 8'd12, 8'd24};

    // Settings of one divider
    typedef struct packed {
        logic [7:0] on_ticks;
        logic [7:0] period_ticks;
    } div_cfg_t;

    // Result of one beat
    typedef struct packed {
        logic [NUM_GATE_OUTPUTS-1:0] gate_levels;
        logic                        led_level;
        logic                        clock_running;
    } result_t;

endpackage

// ===== rtl/midi_clock_gate_divider.sv =====
// ============================================================================
// midi_clock_gate_divider
// MIDI real-time byte in, eight gates (six divided from the clock) and a status LED out.
// ============================================================================
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_ready, midi_byte                    | sink
//  out     | out_valid, out_ready, gate_levels, led_level,    | source
//          | clock_running                                    |
//  cfg     | cfg_write, cfg_index, cfg_data                   | write only
//
//  One beat per cycle sustained while out_ready holds; a byte is captured in the
//  input register and its result is then registered in the output register.
//  The state update is a single pass of four 8-bit increment/compare lanes.
//  Reset is asynchronous, active low; settings return to their defaults.
//  A stalled output holds its beat and the input register backs up behind it.
//
module midi_clock_gate_divider
    import mcgd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  midi_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [NUM_GATE_OUTPUTS-1:0] gate_levels,
    output logic                        led_level,
    output logic                        clock_running,
    input  logic                        cfg_write,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_advance;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    div_cfg_t   div_cfg [NUM_DIVIDERS];

    mcgd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .div_cfg   (div_cfg)
    );

    mcgd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_advance),
        .msg         (s1_byte_reg),
        .div_cfg     (div_cfg),
        .result_next (result_next)
    );

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= midi_byte;
        end
        if (s1_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign gate_levels   = result_reg.gate_levels;
    assign led_level     = result_reg.led_level;
    assign clock_running = result_reg.clock_running;

    // a stopped transport shows all gates low and the LED lit
    a_stopped_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.clock_running) |->
            ((result_reg.gate_levels == '0) && result_reg.led_level))
        else $error("gates active while stopped");

    // an accepted byte lands in the input register
    a_in_captured : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted beat lost at input register");

    // a byte leaving the input register always produces a result beat
    a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("result beat missing");

    // a held result is not overwritten
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !s1_advance)
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/mcgd_cfg_regs.sv =====
// ============================================================================
// mcgd_cfg_regs
// Divider settings register file: on-tick counts and wrap periods.
// ============================================================================
module mcgd_cfg_regs
    import mcgd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output div_cfg_t               div_cfg [NUM_DIVIDERS]
);

    logic [CFG_DATA_W-1:0] regs_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_write && (cfg_index <= REG_PERIOD_TICKS_D))
        begin
            // drop writes beyond the last register
            regs_reg[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int d = 0; d < NUM_DIVIDERS; d++)
        begin
            div_cfg[d].on_ticks     = regs_reg[2*d];
            div_cfg[d].period_ticks = regs_reg[2*d+1];
        end
    end

endmodule

// ===== rtl/mcgd_core.sv =====
// ============================================================================
// mcgd_core
// Transport state, tick counters and gate/LED levels, updated once per beat.
// ============================================================================
module mcgd_core
    import mcgd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] msg,
    input  div_cfg_t   div_cfg [NUM_DIVIDERS],
    output result_t    result_next
);

    logic                        running_reg, running_next;
    logic                        pending_reg, pending_next;
    logic [7:0]                  cnt_reg  [NUM_DIVIDERS];
    logic [7:0]                  cnt_next [NUM_DIVIDERS];
    logic [NUM_GATE_OUTPUTS-1:0] gate_reg, gate_next;
    logic                        led_reg, led_next;
    logic [7:0]                  cnt_inc  [NUM_DIVIDERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b1;
            pending_reg <= 1'b1;
            gate_reg    <= '0;
            led_reg     <= 1'b1;
            for (int d = 0; d < NUM_DIVIDERS; d++)
            begin
                cnt_reg[d] <= '0;
            end
        end
        else
        begin
            running_reg <= running_next;
            pending_reg <= pending_next;
            gate_reg    <= gate_next;
            led_reg     <= led_next;
            for (int d = 0; d < NUM_DIVIDERS; d++)
            begin
                cnt_reg[d] <= cnt_next[d];
            end
        end
    end

    always_comb
    begin
        running_next = running_reg;
        pending_next = pending_reg;
        gate_next    = gate_reg;
        led_next     = led_reg;
        for (int d = 0; d < NUM_DIVIDERS; d++)
        begin
            cnt_inc[d]  = cnt_reg[d] + 8'd1;
            cnt_next[d] = cnt_reg[d];
        end

        if (step)
        begin
            priority if (msg == MSG_START)
            begin
                running_next  = 1'b1;
                pending_next  = 1'b1;
                gate_next[1:0] = 2'b11;
            end
            else if (msg == MSG_STOP)
            begin
                running_next = 1'b0;
                gate_next    = '0;
                led_next     = 1'b1;
            end
            else if ((msg == MSG_CLOCK) && running_reg)
            begin
                if (pending_reg)
                begin
                    // first clock after start or reset: realign all dividers
                    pending_next   = 1'b0;
                    gate_next[1:0] = 2'b00;
                    for (int d = 0; d < NUM_DIVIDERS; d++)
                    begin
                        cnt_next[d] = '0;
                    end
                end
                else
                begin
                    // advance, wrap once the period is reached
                    for (int d = 0; d < NUM_DIVIDERS; d++)
                    begin
                        cnt_next[d] = (div_cfg[d].period_ticks <= cnt_inc[d]) ?
                                      8'd0 : cnt_inc[d];
                    end
                end
                for (int d = 0; d < NUM_DIVIDERS - 1; d++)
                begin
                    gate_next[2*d+2 +: 2] = {2{cnt_next[d] < div_cfg[d].on_ticks}};
                end
                led_next = cnt_next[NUM_DIVIDERS-1] < div_cfg[NUM_DIVIDERS-1].on_ticks;
            end
            else
            begin
                // other bytes leave everything as is
                running_next = running_reg;
            end
        end
    end

    assign result_next.gate_levels   = gate_next;
    assign result_next.led_level     = led_next;
    assign result_next.clock_running = running_next;

endmodule
